// ===== hw/rtl/priority_led_blink_controller_core_assert.svh =====
// ----------------------------------------------------------------------------
// priority_led_blink_controller_core_assert.svh
// assertion macros shared by the checker of the blink controller
// ----------------------------------------------------------------------------
`ifndef PRIORITY_LED_BLINK_CONTROLLER_CORE_ASSERT_SVH
`define PRIORITY_LED_BLINK_CONTROLLER_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PLBC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PLBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/plbc_pkg.sv =====
// ----------------------------------------------------------------------------
// plbc_pkg
// shared widths, constants and types of the priority led blink controller
// ----------------------------------------------------------------------------
package plbc_pkg;

    localparam int SLOT_COUNT_DEF = 4;
    localparam int TIME_W         = 16;
    localparam int SPAN_W         = 32;
    localparam int REP_W          = 16;
    localparam int SLOT_PORT_W    = 2;

    // repeat code meaning run forever
    localparam logic [REP_W-1:0] REP_FOREVER = '1;

    // one entry of the slot table
    typedef struct packed {
        logic [SPAN_W-1:0] on_span;
        logic [SPAN_W-1:0] off_span;
        logic [REP_W-1:0]  reps;
    } entry_t;

    // decision taken on the shown slot at the current time
    typedef struct packed {
        logic             expire;
        logic             to_off;
        logic             to_on;
        logic [REP_W-1:0] rep_next;
    } judge_t;

endpackage

// ===== hw/rtl/priority_led_blink_controller_core.sv =====
// ----------------------------------------------------------------------------
// priority_led_blink_controller_core
// priority led blink controller: slot table, phase timer and sequencer
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low; its result comes as
// a one-cycle done strobe with led, shown_valid and shown_slot and cannot be
// held off. An item runs from transfer to the next possible transfer through
// the steps latch, apply, pick and judge. When no slot is active after the
// apply step the judge step is skipped; when the shown slot expires the pick
// and judge steps run once more, or only the pick step when no slot is left
// to show. The slot table has one read port with registered read data and
// is read once per pick. done rises in the cycle after the last step, in
// which busy is already low, so the next item may be sent together with the
// strobe.
// ----------------------------------------------------------------------------
module priority_led_blink_controller_core #(
    parameter int SLOT_COUNT = plbc_pkg::SLOT_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    output logic                               done,
    input  logic                               cmd,
    input  logic [plbc_pkg::SLOT_PORT_W-1:0]   slot,
    input  logic [plbc_pkg::TIME_W-1:0]        on_time,
    input  logic [plbc_pkg::TIME_W-1:0]        off_time,
    input  logic signed [plbc_pkg::REP_W-1:0]  repeat_count,
    output logic                               led,
    output logic                               shown_valid,
    output logic [plbc_pkg::SLOT_PORT_W-1:0]   shown_slot
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PW     = plbc_pkg::SLOT_PORT_W;

    // sequencer codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_APPLY = 2'd1;
    localparam logic [1:0] ST_PICK  = 2'd2;
    localparam logic [1:0] ST_JUDGE = 2'd3;

    logic [1:0] state_reg, state_next;

    // latched item
    logic                        cmd_reg,  cmd_next;
    logic [PW-1:0]               slot_reg, slot_next;
    logic [plbc_pkg::TIME_W-1:0] on_reg,   on_next;
    logic [plbc_pkg::TIME_W-1:0] off_reg,  off_next;
    logic [plbc_pkg::REP_W-1:0]  rep_reg,  rep_next;

    // display state
    logic [SLOT_COUNT-1:0]       active_reg,  active_next;
    logic [SLOT_W-1:0]           shown_reg,   shown_next;
    logic                        showing_reg, showing_next;
    logic                        phase_on_reg, phase_on_next;
    logic [plbc_pkg::SPAN_W-1:0] elapsed_reg, elapsed_next;
    // shown slot was just chosen, so the judgment only sets the phase
    logic                        fresh_reg,   fresh_next;

    // result registers
    logic          done_reg,  done_next;
    logic          led_reg,   led_next;
    logic          valid_reg, valid_next;
    logic [PW-1:0] sslot_reg, sslot_next;

    // slot table port
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    plbc_pkg::entry_t  mem_wdata;
    plbc_pkg::entry_t  mem_rdata;

    plbc_pkg::entry_t norm_entry;
    logic             norm_active;
    plbc_pkg::judge_t jd;

    logic              any_active;
    logic [SLOT_W-1:0] hi_idx;
    logic [SLOT_W-1:0] slot_idx;
    logic              slot_in_range;
    logic              emit;

    plbc_norm u_norm (
        .on_time      (on_reg),
        .off_time     (off_reg),
        .repeat_count (rep_reg),
        .entry        (norm_entry),
        .active       (norm_active)
    );

    plbc_slot_ram #(
        .DEPTH (SLOT_COUNT),
        .AW    (SLOT_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (hi_idx),
        .rdata (mem_rdata)
    );

    plbc_judge u_judge (
        .entry    (mem_rdata),
        .phase_on (phase_on_reg),
        .elapsed  (elapsed_reg),
        .decision (jd)
    );

    // highest active slot wins
    always_comb
    begin
        any_active = 1'b0;
        hi_idx     = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (active_reg[i])
            begin
                any_active = 1'b1;
                hi_idx     = SLOT_W'(i);
            end
        end
    end

    assign slot_idx      = SLOT_W'(slot_reg);
    // sets to slots beyond the table are dropped
    assign slot_in_range = (int'(slot_reg) < SLOT_COUNT);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        slot_next     = slot_reg;
        on_next       = on_reg;
        off_next      = off_reg;
        rep_next      = rep_reg;
        active_next   = active_reg;
        shown_next    = shown_reg;
        showing_next  = showing_reg;
        phase_on_next = phase_on_reg;
        elapsed_next  = elapsed_reg;
        fresh_next    = fresh_reg;
        mem_we        = 1'b0;
        mem_waddr     = slot_idx;
        mem_wdata     = norm_entry;
        emit          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    slot_next  = slot;
                    on_next    = on_time;
                    off_next   = off_time;
                    rep_next   = repeat_count;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (cmd_reg)
                begin
                    if (slot_in_range)
                    begin
                        mem_we                = 1'b1;
                        active_next[slot_idx] = norm_active;
                        // a set at or above the shown slot forces a new choice
                        if (!showing_reg || slot_idx >= shown_reg)
                        begin
                            showing_next = 1'b0;
                        end
                    end
                end
                else if (showing_reg && elapsed_reg != '1)
                begin
                    // one millisecond tick, saturating
                    elapsed_next = elapsed_reg + plbc_pkg::SPAN_W'(1);
                end
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                // table read of hi_idx is issued in this cycle
                if (!any_active)
                begin
                    showing_next  = 1'b0;
                    phase_on_next = 1'b0;
                    emit          = 1'b1;
                end
                else
                begin
                    if (!showing_reg || shown_reg != hi_idx)
                    begin
                        shown_next   = hi_idx;
                        showing_next = 1'b1;
                        elapsed_next = '0;
                        fresh_next   = 1'b1;
                    end
                    else
                    begin
                        fresh_next = 1'b0;
                    end
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE:
            begin
                if (fresh_reg)
                begin
                    phase_on_next = (mem_rdata.on_span != '0);
                    emit          = 1'b1;
                end
                else if (jd.expire)
                begin
                    // slot used up: drop it and choose again
                    active_next[shown_reg] = 1'b0;
                    showing_next           = 1'b0;
                    state_next             = ST_PICK;
                end
                else if (jd.to_off)
                begin
                    phase_on_next = 1'b0;
                    elapsed_next  = '0;
                    emit          = 1'b1;
                end
                else if (jd.to_on)
                begin
                    // write back the counted-down repeat
                    mem_we         = 1'b1;
                    mem_waddr      = shown_reg;
                    mem_wdata      = mem_rdata;
                    mem_wdata.reps = jd.rep_next;
                    phase_on_next  = 1'b1;
                    elapsed_next   = '0;
                    emit           = 1'b1;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            state_next = ST_IDLE;
        end
    end

    // result of the item: done is high for one cycle, the shown values hold to the next result
    always_comb
    begin
        done_next  = emit;
        led_next   = led_reg;
        valid_next = valid_reg;
        sslot_next = sslot_reg;
        if (emit)
        begin
            led_next   = showing_next && phase_on_next;
            valid_next = showing_next;
            sslot_next = showing_next ? PW'(shown_next) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            active_reg   <= '0;
            shown_reg    <= '0;
            showing_reg  <= 1'b0;
            phase_on_reg <= 1'b0;
            elapsed_reg  <= '0;
            fresh_reg    <= 1'b0;
            done_reg     <= 1'b0;
            led_reg      <= 1'b0;
            valid_reg    <= 1'b0;
            sslot_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            shown_reg    <= shown_next;
            showing_reg  <= showing_next;
            phase_on_reg <= phase_on_next;
            elapsed_reg  <= elapsed_next;
            fresh_reg    <= fresh_next;
            done_reg     <= done_next;
            led_reg      <= led_next;
            valid_reg    <= valid_next;
            sslot_reg    <= sslot_next;
        end
    end

    // item payload needs no reset
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        slot_reg <= slot_next;
        on_reg   <= on_next;
        off_reg  <= off_next;
        rep_reg  <= rep_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign led         = led_reg;
    assign shown_valid = valid_reg;
    assign shown_slot  = sslot_reg;

endmodule

// ===== hw/rtl/plbc_slot_ram.sv =====
// ----------------------------------------------------------------------------
// plbc_slot_ram
// slot table: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module plbc_slot_ram #(
    parameter int DEPTH = plbc_pkg::SLOT_COUNT_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  plbc_pkg::entry_t wdata,
    input  logic [AW-1:0]    raddr,
    output plbc_pkg::entry_t rdata
);

    plbc_pkg::entry_t mem [DEPTH];
    plbc_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/plbc_norm.sv =====
// ----------------------------------------------------------------------------
// plbc_norm
// pattern normalizer: static patterns get time times repeat, repeat of one
// ----------------------------------------------------------------------------
module plbc_norm (
    input  logic [plbc_pkg::TIME_W-1:0] on_time,
    input  logic [plbc_pkg::TIME_W-1:0] off_time,
    input  logic [plbc_pkg::REP_W-1:0]  repeat_count,
    output plbc_pkg::entry_t            entry,
    output logic                        active
);

    logic                        rep_pos;
    logic                        on_zero;
    logic                        off_zero;
    logic [plbc_pkg::TIME_W-1:0] base;
    logic [plbc_pkg::SPAN_W-1:0] prod;

    assign rep_pos  = !repeat_count[plbc_pkg::REP_W-1] && (repeat_count != '0);
    assign on_zero  = (on_time == '0);
    assign off_zero = (off_time == '0);
    assign base     = off_zero ? on_time : off_time;
    // positive repeat fits in 15 bits, so the product never wraps
    assign prod     = {{(plbc_pkg::SPAN_W-plbc_pkg::TIME_W){1'b0}}, base}
                    * {{(plbc_pkg::SPAN_W-plbc_pkg::REP_W+1){1'b0}},
                       repeat_count[plbc_pkg::REP_W-2:0]};

    always_comb
    begin
        entry.on_span  = plbc_pkg::SPAN_W'(on_time);
        entry.off_span = plbc_pkg::SPAN_W'(off_time);
        entry.reps     = repeat_count;
        if (rep_pos && !on_zero && off_zero)
        begin
            entry.on_span = prod;
            entry.reps    = plbc_pkg::REP_W'(1);
        end
        else if (rep_pos && on_zero && !off_zero)
        begin
            entry.off_span = prod;
            entry.reps     = plbc_pkg::REP_W'(1);
        end
    end

    assign active = (repeat_count != '0) && !(on_zero && off_zero);

endmodule

// ===== hw/rtl/plbc_judge.sv =====
// ----------------------------------------------------------------------------
// plbc_judge
// phase judgment of the shown slot: phase change, repeat countdown, expiry
// ----------------------------------------------------------------------------
module plbc_judge (
    input  plbc_pkg::entry_t            entry,
    input  logic                        phase_on,
    input  logic [plbc_pkg::SPAN_W-1:0] elapsed,
    output plbc_pkg::judge_t            decision
);

    logic                        is_static;
    logic [plbc_pkg::SPAN_W-1:0] dur;
    logic                        rep_pos;
    logic [plbc_pkg::REP_W-1:0]  rep_dec;

    assign is_static = (entry.on_span == '0) || (entry.off_span == '0);
    assign dur       = (entry.off_span == '0) ? entry.on_span : entry.off_span;
    assign rep_pos   = !entry.reps[plbc_pkg::REP_W-1] && (entry.reps != '0);
    // negative repeats never count down
    assign rep_dec   = rep_pos ? entry.reps - plbc_pkg::REP_W'(1) : entry.reps;

    always_comb
    begin
        decision          = '0;
        decision.rep_next = rep_dec;
        if (is_static)
        begin
            decision.expire = (entry.reps != plbc_pkg::REP_FOREVER) && (elapsed >= dur);
        end
        else if (phase_on)
        begin
            decision.to_off = (elapsed >= entry.on_span);
        end
        else if (elapsed >= entry.off_span)
        begin
            decision.expire = (rep_dec == '0);
            decision.to_on  = (rep_dec != '0);
        end
    end

endmodule

// ===== hw/rtl/plbc_checker.sv =====
// ----------------------------------------------------------------------------
// plbc_checker
// port-level checks of the blink controller, bound to the top level
// ----------------------------------------------------------------------------
`include "priority_led_blink_controller_core_assert.svh"

module plbc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             done,
    input logic                             led,
    input logic                             shown_valid,
    input logic [plbc_pkg::SLOT_PORT_W-1:0] shown_slot
);

    // led is only lit by a shown slot
    `PLBC_ASSERT_SAME(a_led_needs_shown, done && led, shown_valid, "led on with no slot shown")

    // with nothing shown the slot reads zero
    `PLBC_ASSERT_SAME(a_slot_zero, done && !shown_valid, shown_slot == '0, "slot not zero")

    // a result ends the item, so the block is free in that cycle
    `PLBC_ASSERT_SAME(a_done_free, done, !busy, "busy while result shown")

    // an accepted transfer keeps the block busy and yields no result at once
    `PLBC_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "no busy after transfer")

endmodule

bind priority_led_blink_controller_core plbc_checker u_plbc_checker (.*);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the priority led blink controller core
// ----------------------------------------------------------------------------
// Set and tick commands are driven over the start/busy handshake. Each
// transfer is fed to a scoreboard that keeps its own copy of the slot table
// and phase timer and works out the led level and shown slot. Every done
// strobe is checked against the oldest of those predictions. A short
// directed run covers the corner cases; a random run with mostly short
// timings follows, so that blinks count down and timed patterns expire often.
// ----------------------------------------------------------------------------
module testbench;

    import plbc_pkg::*;

    localparam int SLOTS        = SLOT_COUNT_DEF;
    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 16;

    // command codes on the cmd port
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // what the block shows after one item
    typedef struct packed {
        logic                   led;
        logic                   valid;
        logic [SLOT_PORT_W-1:0] slot;
    } shown_t;

    // ------------------------------------------------------------------------
    // scoreboard: slot table copy, led prediction and the queue of results
    // ------------------------------------------------------------------------
    class blink_scoreboard;

        logic [SPAN_W-1:0]       on_span[SLOTS];
        logic [SPAN_W-1:0]       off_span[SLOTS];
        logic signed [REP_W-1:0] reps_left[SLOTS];
        logic                    active[SLOTS];
        logic [SLOT_PORT_W-1:0]  shown_idx;
        logic                    showing;
        logic                    lit_phase;
        logic [SPAN_W-1:0]       elapsed;
        shown_t                  expected_shown[$];
        int                      errors;

        function new();
            for (int i = 0; i < SLOTS; i++)
                wipe_slot(i);
            shown_idx = '0;
            showing   = 1'b0;
            lit_phase = 1'b0;
            elapsed   = '0;
            errors    = 0;
        endfunction

        function void wipe_slot(int s);
            on_span[s]   = '0;
            off_span[s]  = '0;
            reps_left[s] = '0;
            active[s]    = 1'b0;
        endfunction

        function int highest_active();
            for (int i = SLOTS - 1; i >= 0; i--)
                if (active[i])
                    return i;
            return -1;
        endfunction

        // advances the phase of the shown slot; 1 when the slot ran out
        function bit run_phase();
            logic [SPAN_W-1:0]       on_w;
            logic [SPAN_W-1:0]       off_w;
            logic [SPAN_W-1:0]       span;
            logic signed [REP_W-1:0] rep_w;
            on_w  = on_span[shown_idx];
            off_w = off_span[shown_idx];
            rep_w = reps_left[shown_idx];
            if (on_w == 0 || off_w == 0)
            begin
                // static pattern: one span, no blinking
                span = (off_w == 0) ? on_w : off_w;
                if (rep_w == REP_FOREVER)
                    return 1'b0;
                if (elapsed >= span)
                begin
                    wipe_slot(shown_idx);
                    showing = 1'b0;
                    return 1'b1;
                end
                return 1'b0;
            end
            if (lit_phase)
            begin
                if (elapsed >= on_w)
                begin
                    lit_phase = 1'b0;
                    elapsed   = '0;
                end
                return 1'b0;
            end
            if (elapsed < off_w)
                return 1'b0;
            // end of an off phase: one repeat used, negative counts never end
            if (rep_w > 0)
                rep_w = rep_w - 16'sd1;
            reps_left[shown_idx] = rep_w;
            if (rep_w == 0)
            begin
                wipe_slot(shown_idx);
                showing = 1'b0;
                return 1'b1;
            end
            lit_phase = 1'b1;
            elapsed   = '0;
            return 1'b0;
        endfunction

        function void choose_shown();
            int top;
            for (int pass = 0; pass <= SLOTS; pass++)
            begin
                top = highest_active();
                if (top < 0)
                begin
                    showing   = 1'b0;
                    lit_phase = 1'b0;
                    return;
                end
                if (!showing || shown_idx != top[SLOT_PORT_W-1:0])
                begin
                    shown_idx = top[SLOT_PORT_W-1:0];
                    showing   = 1'b1;
                    elapsed   = '0;
                    lit_phase = (on_span[top] != 0);
                end
                if (!run_phase())
                    return;
            end
        endfunction

        function int pending();
            return expected_shown.size();
        endfunction

        // one accepted item: update the copy and queue what the block shows
        function void note_transfer(logic c, logic [SLOT_PORT_W-1:0] s,
                                    logic [TIME_W-1:0] on, logic [TIME_W-1:0] off,
                                    logic signed [REP_W-1:0] rep);
            logic [SPAN_W-1:0]       on_w;
            logic [SPAN_W-1:0]       off_w;
            logic signed [REP_W-1:0] rep_w;
            shown_t                  res;
            on_w  = {{(SPAN_W-TIME_W){1'b0}}, on};
            off_w = {{(SPAN_W-TIME_W){1'b0}}, off};
            rep_w = rep;
            if (c == CMD_SET)
            begin
                if (s < SLOTS)
                begin
                    // static patterns get their whole time in one span
                    if (on != 0 && off == 0 && rep > 0)
                    begin
                        on_w  = on_w * {{(SPAN_W-REP_W){1'b0}}, rep};
                        rep_w = 1;
                    end
                    else if (off != 0 && on == 0 && rep > 0)
                    begin
                        off_w = off_w * {{(SPAN_W-REP_W){1'b0}}, rep};
                        rep_w = 1;
                    end
                    on_span[s]   = on_w;
                    off_span[s]  = off_w;
                    reps_left[s] = rep_w;
                    active[s]    = !(rep_w == 0 || (on_w == 0 && off_w == 0));
                    if (!showing || s >= shown_idx)
                        showing = 1'b0;
                end
            end
            else if (showing && elapsed != '1)
            begin
                elapsed = elapsed + 1;
            end
            choose_shown();
            res.led   = showing && lit_phase;
            res.valid = showing;
            res.slot  = showing ? shown_idx : '0;
            expected_shown.push_back(res);
        endfunction

        function void check_strobe(logic led, logic valid, logic [SLOT_PORT_W-1:0] slot);
            shown_t want;
            if (expected_shown.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("error: unexpected result led %0b valid %0b slot %0d",
                             led, valid, slot);
                return;
            end
            want = expected_shown.pop_front();
            if (led !== want.led || valid !== want.valid || slot !== want.slot)
            begin
                errors++;
                if (errors <= 10)
                    $display("error: expected led %0b valid %0b slot %0d, got led %0b valid %0b slot %0d",
                             want.led, want.valid, want.slot, led, valid, slot);
            end
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    done;
    logic                    cmd;
    logic [SLOT_PORT_W-1:0]  slot;
    logic [TIME_W-1:0]       on_time;
    logic [TIME_W-1:0]       off_time;
    logic signed [REP_W-1:0] repeat_count;
    logic                    led;
    logic                    shown_valid;
    logic [SLOT_PORT_W-1:0]  shown_slot;

    blink_scoreboard sb;
    bit              gaps_on;
    int              cycles;

    priority_led_blink_controller_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .done         (done),
        .cmd          (cmd),
        .slot         (slot),
        .on_time      (on_time),
        .off_time     (off_time),
        .repeat_count (repeat_count),
        .led          (led),
        .shown_valid  (shown_valid),
        .shown_slot   (shown_slot)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // results cannot be held off: every done strobe is checked at its edge
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_strobe(led, shown_valid, shown_slot);
    end

    // hard stop if the block hangs or drops a result
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one transfer; start stays high until busy is seen low at an edge
    task automatic send_item(input logic c, input logic [SLOT_PORT_W-1:0] s,
                             input logic [TIME_W-1:0] on, input logic [TIME_W-1:0] off,
                             input logic signed [REP_W-1:0] rep);
        // random sender gap, about 23 items in a hundred
        if (gaps_on && $urandom_range(0, 99) < 23)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        start        <= 1'b1;
        cmd          <= c;
        slot         <= s;
        on_time      <= on;
        off_time     <= off;
        repeat_count <= rep;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_transfer(c, s, on, off, rep);
    endtask

    // tick with junk in the unused fields, so those bits toggle too
    task automatic send_tick();
        send_item(CMD_TICK, SLOT_PORT_W'($urandom), TIME_W'($urandom),
                  TIME_W'($urandom), REP_W'($urandom));
    endtask

    // hold off the sender until the block has reported everything
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // mostly short spans so phases end within a few ticks
    function automatic logic [TIME_W-1:0] pick_span();
        case ($urandom_range(0, 9))
            7, 8:    return TIME_W'($urandom_range(5, 20));
            9:       return TIME_W'($urandom);
            default: return TIME_W'($urandom_range(0, 4));
        endcase
    endfunction

    function automatic logic signed [REP_W-1:0] pick_repeat();
        case ($urandom_range(0, 9))
            0, 1:    return REP_FOREVER;
            2:       return '0;
            8:       return -REP_W'($urandom_range(2, 40));
            9:       return REP_W'($urandom);
            default: return REP_W'($urandom_range(1, 4));
        endcase
    endfunction

    // random pattern: mostly blinks, some static, some clears
    task automatic send_random_set();
        logic [TIME_W-1:0]       on;
        logic [TIME_W-1:0]       off;
        logic signed [REP_W-1:0] rep;
        on  = pick_span();
        off = pick_span();
        rep = pick_repeat();
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                if (on == 0)
                    on = 1;
                if (off == 0)
                    off = 1;
            end
            4, 5:
            begin
                off = '0;
                if (on == 0)
                    on = 1;
            end
            6:
            begin
                on = '0;
                if (off == 0)
                    off = 1;
            end
            7:
                rep = '0;
            default:
                ;
        endcase
        send_item(CMD_SET, SLOT_PORT_W'($urandom), on, off, rep);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = CMD_TICK;
        slot         = '0;
        on_time      = '0;
        off_time     = '0;
        repeat_count = '0;
        cycles       = 0;
        gaps_on      = 1'b1;
        sb           = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tick with nothing shown, all fields high
        send_item(CMD_TICK, 2'd3, '1, '1, REP_FOREVER);
        // single blink: on, off, then the slot runs out and nothing is shown
        send_item(CMD_SET, 2'd0, 16'd1, 16'd1, 16'sd1);
        send_tick();
        send_tick();
        // static on pattern, time multiplied by the count
        send_item(CMD_SET, 2'd1, 16'd2, 16'd0, 16'sd2);
        // inactive pattern above the shown slot restarts the phase
        send_item(CMD_SET, 2'd3, 16'd0, 16'd0, 16'sd5);
        // set below the shown slot is only stored
        send_item(CMD_SET, 2'd0, 16'd1, 16'd1, REP_FOREVER);
        // static slot expires, the lower blink takes over in the same item
        repeat (4) send_tick();
        // static off pattern that never expires
        send_item(CMD_SET, 2'd2, 16'd0, 16'd3, REP_FOREVER);
        send_tick();
        // blink with a negative count runs forever
        send_item(CMD_SET, 2'd3, 16'd1, 16'd1, -16'sd5);
        repeat (3) send_tick();
        // static with a negative count expires after one span
        send_item(CMD_SET, 2'd3, 16'd1, 16'd0, -16'sd300);
        send_tick();
        // field extremes
        send_item(CMD_SET, 2'd2, 16'hffff, 16'd0, 16'sh7fff);
        send_item(CMD_SET, 2'd1, 16'hffff, 16'hffff, 16'sh8000);
        send_item(CMD_SET, 2'd3, 16'h8000, 16'h7fff, 16'sd0);
        send_tick();
        send_item(CMD_SET, 2'd2, 16'd0, 16'd0, 16'sd0);
        send_tick();
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // a long stretch with back-to-back transfers
            gaps_on = !(n >= 250 && n < 400);
            if (n % 150 == 149)
                drain();
            if ($urandom_range(0, 99) < 65)
                send_tick();
            else
                send_random_set();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
